>>> design/knnbc_pkg.sv
// Shared types and constants for the two-label nearest-neighbor classifier.
package knnbc_pkg;

    localparam int DIMS_W    = 7;
    localparam int K_W       = 4;
    localparam int DIMS_RESET = 50;
    localparam int K_RESET    = 5;
    localparam int APB_DW     = 32;
    localparam int APB_AW     = 3;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_TRAIN = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_e_t;

    typedef enum logic {
        REG_DIMS = 1'b0,
        REG_K    = 1'b1
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_VOTE
    } state_t;

    // Sideband that travels with one feature pair through the distance pipeline.
    typedef struct packed {
        logic first;
        logic last;
        logic label;
    } mac_tag_t;

    // Broadcast to every cell of the neighbor chain.
    typedef struct packed {
        logic insert;
        logic clear;
        logic label;
    } cell_cmd_t;

    // What a cell hands to its right-hand neighbor.
    typedef struct packed {
        logic valid;
        logic label;
        logic beaten;
    } cell_ctl_t;

endpackage

>>> design/knnbc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module knnbc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    clk,
    we,
    waddr,
    wdata,
    raddr,
    rdata
);
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    input  logic              clk;
    input  logic              we;
    input  logic [ADDR_W-1:0] waddr;
    input  logic [WIDTH-1:0]  wdata;
    input  logic [ADDR_W-1:0] raddr;
    output logic [WIDTH-1:0]  rdata;

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> design/knnbc_mac.sv
// Distance pipeline: absolute difference, square, and per-point accumulation.
module knnbc_mac #(
    parameter int FEATURE_BITS = 16,
    parameter int DIST_W       = 38
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  knnbc_pkg::mac_tag_t         in_tag,
    input  logic [FEATURE_BITS-1:0]     train_feat,
    input  logic [FEATURE_BITS-1:0]     query_feat,
    output logic                        cand_valid,
    output logic                        cand_label,
    output logic [DIST_W-1:0]           cand_dist,
    output logic                        pending
);
    import knnbc_pkg::*;

    logic                      valid_a_reg;
    mac_tag_t                  tag_a_reg;
    logic [FEATURE_BITS-1:0]   diff_a_reg;
    logic                      valid_b_reg;
    mac_tag_t                  tag_b_reg;
    logic [2*FEATURE_BITS-1:0] sq_b_reg;
    logic [DIST_W-1:0]         acc_reg;
    logic [DIST_W-1:0]         acc_next;
    logic                      cand_valid_reg;
    logic                      cand_label_reg;
    logic [DIST_W-1:0]         cand_dist_reg;
    logic [FEATURE_BITS-1:0]   diff_next;

    assign diff_next = (query_feat >= train_feat) ? (query_feat - train_feat)
                                                  : (train_feat - query_feat);

    // The first dimension of a point restarts the sum.
    assign acc_next = tag_b_reg.first ? DIST_W'(sq_b_reg) : (acc_reg + DIST_W'(sq_b_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg    <= 1'b0;
            valid_b_reg    <= 1'b0;
            cand_valid_reg <= 1'b0;
        end
        else
        begin
            valid_a_reg    <= in_valid;
            valid_b_reg    <= valid_a_reg;
            cand_valid_reg <= valid_b_reg && tag_b_reg.last;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_a_reg  <= in_tag;
        diff_a_reg <= diff_next;
        tag_b_reg  <= tag_a_reg;
        sq_b_reg   <= diff_a_reg * diff_a_reg;
        if (valid_b_reg)
        begin
            acc_reg <= acc_next;
            if (tag_b_reg.last)
            begin
                cand_dist_reg  <= acc_next;
                cand_label_reg <= tag_b_reg.label;
            end
        end
    end

    assign cand_valid = cand_valid_reg;
    assign cand_label = cand_label_reg;
    assign cand_dist  = cand_dist_reg;
    assign pending    = valid_a_reg || valid_b_reg || cand_valid_reg;

endmodule

>>> design/knnbc_cell.sv
// One cell of the sorted neighbor chain: holds one distance and label.
module knnbc_cell #(
    parameter int DIST_W = 38
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  knnbc_pkg::cell_cmd_t  cmd,
    input  logic [DIST_W-1:0]     cand_dist,
    input  logic                  enable,
    input  knnbc_pkg::cell_ctl_t  prev_ctl,
    input  logic [DIST_W-1:0]     prev_dist,
    output knnbc_pkg::cell_ctl_t  ctl_out,
    output logic [DIST_W-1:0]     dist_out
);
    import knnbc_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic              label_reg;
    logic [DIST_W-1:0] dist_reg;
    logic              beaten;
    logic              take_cand;
    logic              take_prev;

    // An empty cell counts as infinitely far; an equal distance keeps the older point.
    assign beaten    = !valid_reg || (dist_reg > cand_dist);
    assign take_cand = cmd.insert && enable && beaten && !prev_ctl.beaten;
    assign take_prev = cmd.insert && enable && beaten && prev_ctl.beaten;

    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.clear)
        begin
            valid_next = 1'b0;
        end
        else if (take_cand)
        begin
            valid_next = 1'b1;
        end
        else if (take_prev)
        begin
            valid_next = prev_ctl.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_cand)
        begin
            dist_reg  <= cand_dist;
            label_reg <= cmd.label;
        end
        else if (take_prev)
        begin
            dist_reg  <= prev_dist;
            label_reg <= prev_ctl.label;
        end
    end

    assign ctl_out.valid  = valid_reg;
    assign ctl_out.label  = label_reg;
    assign ctl_out.beaten = beaten;
    assign dist_out       = dist_reg;

endmodule

>>> design/knn_binary_classifier_core.sv
// Top level of the two-label nearest-neighbor classifier: control, stores and neighbor chain.
//
// Clear and training features leave busy low: busy stays low and the next transaction
// can start at once. A query feature other than the last also leaves busy low. The last
// feature of a query starts a scan of the training store that holds busy high through the
// scan, drain and vote; one feature pair is read from the training RAM and fed to the
// single subtract-square-accumulate pipeline each cycle. An empty store skips the scan
// and goes straight to the vote. The result appears on predicted_label and neighbours_used
// for exactly one cycle with result_valid high; the receiver must take it then. There is
// no clearing pass after reset, and the training store reads as undefined until it has
// been written.
module knn_binary_classifier_core #(
    parameter int TRAIN_SLOTS  = 1024,
    parameter int MAX_DIM      = 64,
    parameter int MAX_K        = 15,
    parameter int FEATURE_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        command,
    input  logic [FEATURE_BITS-1:0]           feature_value,
    input  logic                              train_label,
    output logic                              result_valid,
    output logic                              predicted_label,
    output logic [knnbc_pkg::K_W-1:0]         neighbours_used,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [knnbc_pkg::APB_AW-1:0]      paddr,
    input  logic [knnbc_pkg::APB_DW-1:0]      pwdata,
    output logic [knnbc_pkg::APB_DW-1:0]      prdata,
    output logic                              pready
);
    import knnbc_pkg::*;

    localparam int IDX_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int PT_W    = (TRAIN_SLOTS > 1) ? $clog2(TRAIN_SLOTS) : 1;
    localparam int CNT_W   = $clog2(TRAIN_SLOTS + 1);
    localparam int DIST_W  = 2 * FEATURE_BITS + IDX_W;
    localparam int VOTE_W  = $clog2(MAX_K + 1);
    localparam int TR_ADDR = PT_W + IDX_W;

    // Configuration registers.
    logic [DIMS_W-1:0] dims_reg;
    logic [K_W-1:0]    k_reg;
    logic [DIMS_W-1:0] dims_eff;
    logic [K_W-1:0]    k_eff;
    logic              cfg_write;

    // Loading state.
    logic [CNT_W-1:0]  train_count_reg;
    logic [IDX_W-1:0]  elem_idx_reg;
    logic              loading_query_reg;
    logic [IDX_W-1:0]  idx_eff;
    logic              accept;
    cmd_e_t            cmd;
    logic              is_query;
    logic              last_elem;
    logic              store_full;

    // Sequencer.
    state_t            state_reg;
    state_t            state_next;
    logic              issue;
    logic              query_done;
    logic [PT_W-1:0]   pt_reg;
    logic [IDX_W-1:0]  dim_reg;
    logic              last_dim;
    logic              last_pt;
    logic              s1_valid_reg;
    logic              s1_first_reg;
    logic              s1_last_reg;

    // Memories.
    logic               tr_we;
    logic [TR_ADDR-1:0] tr_waddr;
    logic [TR_ADDR-1:0] tr_raddr;
    logic [FEATURE_BITS-1:0] tr_rdata;
    logic               lb_we;
    logic               lb_rdata;
    logic               q_we;
    logic [FEATURE_BITS-1:0] q_rdata;

    // Distance pipeline and neighbor chain.
    mac_tag_t          mac_tag;
    logic              mac_cand_valid;
    logic              mac_cand_label;
    logic [DIST_W-1:0] mac_cand_dist;
    logic              mac_pending;
    cell_cmd_t         chain_cmd;
    cell_ctl_t         cell_ctl [MAX_K];
    logic [DIST_W-1:0] cell_dist [MAX_K];

    // Vote.
    logic [VOTE_W-1:0] vote_used;
    logic [VOTE_W-1:0] vote_ones;
    logic              result_valid_reg;
    logic              predicted_reg;
    logic [K_W-1:0]    used_reg;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dims_reg <= DIMS_W'(DIMS_RESET);
            k_reg    <= K_W'(K_RESET);
        end
        else if (cfg_write)
        begin
            case (reg_idx_t'(paddr[2]))
                REG_DIMS: dims_reg <= pwdata[DIMS_W-1:0];
                REG_K:    k_reg    <= pwdata[K_W-1:0];
                default:  ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx_t'(paddr[2]))
            REG_DIMS: prdata = APB_DW'(dims_reg);
            REG_K:    prdata = APB_DW'(k_reg);
            default:  prdata = '0;
        endcase
    end

    always_comb
    begin
        if (dims_reg == '0)
            dims_eff = DIMS_W'(1);
        else if (32'(dims_reg) > MAX_DIM)
            dims_eff = DIMS_W'(MAX_DIM);
        else
            dims_eff = dims_reg;
    end

    always_comb
    begin
        if (k_reg == '0)
            k_eff = K_W'(1);
        else if (32'(k_reg) > MAX_K)
            k_eff = K_W'(MAX_K);
        else
            k_eff = k_reg;
    end

    // ---------------- loading ----------------
    assign accept   = start && !busy;
    assign cmd      = cmd_e_t'(command);
    assign is_query = (cmd == CMD_QUERY);
    // A feature of the other kind abandons the partial point in progress.
    assign idx_eff  = ((elem_idx_reg != '0) && (is_query != loading_query_reg)) ? '0
                                                                                : elem_idx_reg;
    assign last_elem  = (32'(idx_eff) + 1) >= 32'(dims_eff);
    assign store_full = (32'(train_count_reg) >= TRAIN_SLOTS);
    assign query_done = accept && is_query && last_elem;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            train_count_reg   <= '0;
            elem_idx_reg      <= '0;
            loading_query_reg <= 1'b0;
        end
        else if (accept)
        begin
            case (cmd)
                CMD_CLEAR:
                begin
                    train_count_reg <= '0;
                    elem_idx_reg    <= '0;
                end
                CMD_TRAIN, CMD_QUERY:
                begin
                    loading_query_reg <= is_query;
                    if (last_elem)
                    begin
                        elem_idx_reg <= '0;
                        if (!is_query && !store_full)
                        begin
                            train_count_reg <= train_count_reg + CNT_W'(1);
                        end
                    end
                    else
                    begin
                        elem_idx_reg <= idx_eff + IDX_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    assign tr_we    = accept && (cmd == CMD_TRAIN) && !store_full;
    assign lb_we    = tr_we && (idx_eff == '0);
    assign q_we     = accept && is_query;
    assign tr_waddr = {train_count_reg[PT_W-1:0], idx_eff};
    assign tr_raddr = {pt_reg, dim_reg};

    knnbc_ram #(
        .WIDTH (FEATURE_BITS),
        .DEPTH (1 << TR_ADDR)
    ) u_train_ram (
        .clk   (clk),
        .we    (tr_we),
        .waddr (tr_waddr),
        .wdata (feature_value),
        .raddr (tr_raddr),
        .rdata (tr_rdata)
    );

    knnbc_ram #(
        .WIDTH (1),
        .DEPTH (1 << PT_W)
    ) u_label_ram (
        .clk   (clk),
        .we    (lb_we),
        .waddr (train_count_reg[PT_W-1:0]),
        .wdata (train_label),
        .raddr (pt_reg),
        .rdata (lb_rdata)
    );

    knnbc_ram #(
        .WIDTH (FEATURE_BITS),
        .DEPTH (1 << IDX_W)
    ) u_query_ram (
        .clk   (clk),
        .we    (q_we),
        .waddr (idx_eff),
        .wdata (feature_value),
        .raddr (dim_reg),
        .rdata (q_rdata)
    );

    // ---------------- sequencer ----------------
    assign last_dim = (32'(dim_reg) + 1) >= 32'(dims_eff);
    assign last_pt  = (32'(pt_reg) + 1) >= 32'(train_count_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (query_done)
                    state_next = (train_count_reg == '0) ? ST_VOTE : ST_SCAN;
            end
            ST_SCAN:
            begin
                if (last_dim && last_pt)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (!s1_valid_reg && !mac_pending)
                    state_next = ST_VOTE;
            end
            ST_VOTE:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        busy  = 1'b1;
        issue = 1'b0;
        case (state_reg)
            ST_IDLE:  busy  = 1'b0;
            ST_SCAN:  issue = 1'b1;
            ST_DRAIN: ;
            ST_VOTE:  ;
            default:  ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            pt_reg       <= '0;
            dim_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            s1_valid_reg <= issue;
            if (query_done)
            begin
                pt_reg  <= '0;
                dim_reg <= '0;
            end
            else if (issue)
            begin
                if (last_dim)
                begin
                    dim_reg <= '0;
                    pt_reg  <= pt_reg + PT_W'(1);
                end
                else
                begin
                    dim_reg <= dim_reg + IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_first_reg <= (dim_reg == '0);
        s1_last_reg  <= last_dim;
    end

    // ---------------- distance pipeline ----------------
    assign mac_tag.first = s1_first_reg;
    assign mac_tag.last  = s1_last_reg;
    assign mac_tag.label = lb_rdata;

    knnbc_mac #(
        .FEATURE_BITS (FEATURE_BITS),
        .DIST_W       (DIST_W)
    ) u_mac (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s1_valid_reg),
        .in_tag     (mac_tag),
        .train_feat (tr_rdata),
        .query_feat (q_rdata),
        .cand_valid (mac_cand_valid),
        .cand_label (mac_cand_label),
        .cand_dist  (mac_cand_dist),
        .pending    (mac_pending)
    );

    // ---------------- neighbor chain ----------------
    assign chain_cmd.insert = mac_cand_valid;
    assign chain_cmd.clear  = query_done;
    assign chain_cmd.label  = mac_cand_label;

    for (genvar j = 0; j < MAX_K; j++)
    begin : g_cell
        cell_ctl_t         prev_ctl;
        logic [DIST_W-1:0] prev_dist;

        if (j == 0)
        begin : g_head
            assign prev_ctl  = '0;
            assign prev_dist = '0;
        end
        else
        begin : g_link
            assign prev_ctl  = cell_ctl[j-1];
            assign prev_dist = cell_dist[j-1];
        end

        knnbc_cell #(
            .DIST_W (DIST_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (chain_cmd),
            .cand_dist (mac_cand_dist),
            .enable    (32'(k_eff) > j),
            .prev_ctl  (prev_ctl),
            .prev_dist (prev_dist),
            .ctl_out   (cell_ctl[j]),
            .dist_out  (cell_dist[j])
        );
    end

    // ---------------- vote ----------------
    always_comb
    begin
        vote_used = '0;
        vote_ones = '0;
        for (int j = 0; j < MAX_K; j++)
        begin
            vote_used = vote_used + VOTE_W'(cell_ctl[j].valid);
            vote_ones = vote_ones + VOTE_W'(cell_ctl[j].valid && cell_ctl[j].label);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= (state_reg == ST_VOTE);
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_VOTE)
        begin
            // A tie in the vote, and an empty store, both give label 1.
            predicted_reg <= ({1'b0, vote_ones, 1'b0} >= {2'b00, vote_used});
            used_reg      <= K_W'(vote_used);
        end
    end

    assign result_valid    = result_valid_reg;
    assign predicted_label = predicted_reg;
    assign neighbours_used = used_reg;

    // ---------------- assertions ----------------
    a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe lasted more than one cycle");

    a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy)
        else $error("result strobe while still busy");

    a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (train_count_reg != '0))
        else $error("scan started on an empty training store");

    a_vote_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_VOTE) |-> (!mac_pending && !s1_valid_reg))
        else $error("vote taken with distances still in flight");

    a_vote_within_k: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_VOTE) |-> (32'(vote_used) <= 32'(k_eff)))
        else $error("more neighbors kept than k");

endmodule

>>> tb/knn_classifier_checker.sv
// Checker for the nearest-neighbor classifier: tracks its state, predicts each vote, compares.
module knn_classifier_checker #(
    parameter int TRAIN_SLOTS  = 1024,
    parameter int MAX_DIM      = 64,
    parameter int MAX_K        = 15,
    parameter int FEATURE_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic [1:0]                    command,
    input  logic [FEATURE_BITS-1:0]       feature_value,
    input  logic                          train_label,
    input  logic                          result_valid,
    input  logic                          predicted_label,
    input  logic [knnbc_pkg::K_W-1:0]     neighbours_used,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [knnbc_pkg::APB_AW-1:0]  paddr,
    input  logic [knnbc_pkg::APB_DW-1:0]  pwdata,
    input  logic                          pready,
    output int                            mismatches,
    output int                            pending_votes,
    output int                            votes_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import knnbc_pkg::*;

    typedef struct packed {
        logic            label;
        logic [K_W-1:0]  used;
    } vote_t;

    logic [DIMS_W-1:0]       dims_reg;
    logic [K_W-1:0]          k_reg;
    logic [FEATURE_BITS-1:0] point_store [TRAIN_SLOTS*MAX_DIM];
    logic                    label_store [TRAIN_SLOTS];
    logic [FEATURE_BITS-1:0] query_vec [MAX_DIM];
    int                      stored_points;
    int                      elem_pos;
    bit                      in_query;
    vote_t                   expected_votes [$];
    int                      err_count;
    int                      vote_count;

    function automatic int active_dims();
        if (dims_reg == 0) return 1;
        if (dims_reg > MAX_DIM) return MAX_DIM;
        return int'(dims_reg);
    endfunction

    function automatic int active_k();
        if (k_reg == 0) return 1;
        if (k_reg > MAX_K) return MAX_K;
        return int'(k_reg);
    endfunction

    // Nearest-k search over the stored points in load order; a strict compare
    // keeps the earlier point ahead on equal distance.
    function automatic vote_t classify_query(int dims, int k);
        logic [63:0]             near_dist [MAX_K];
        logic                    near_label [MAX_K];
        logic [63:0]             acc;
        logic [63:0]             gap;
        logic [FEATURE_BITS-1:0] t_val;
        logic [FEATURE_BITS-1:0] q_val;
        int                      used;
        int                      ones;
        int                      pos;
        vote_t                   v;
        used = 0;
        ones = 0;
        for (int p = 0; p < stored_points; p++)
        begin
            acc = '0;
            for (int i = 0; i < dims; i++)
            begin
                t_val = point_store[p*MAX_DIM + i];
                q_val = query_vec[i];
                gap = (q_val >= t_val) ? q_val - t_val : t_val - q_val;
                acc += gap * gap;
            end
            if (used == k)
            begin
                if (acc >= near_dist[k-1]) continue;
                pos = k - 1;
            end
            else
            begin
                pos = used;
                used++;
            end
            while (pos > 0 && near_dist[pos-1] > acc)
            begin
                near_dist[pos]  = near_dist[pos-1];
                near_label[pos] = near_label[pos-1];
                pos--;
            end
            near_dist[pos]  = acc;
            near_label[pos] = label_store[p];
        end
        for (int p = 0; p < used; p++) ones += near_label[p];
        v.label = (2 * ones >= used);
        v.used  = K_W'(used);
        return v;
    endfunction

    function automatic void absorb_item(cmd_e_t cmd, logic [FEATURE_BITS-1:0] feat,
                                        logic lbl);
        int dims;
        bit is_q;
        bit last;
        dims = active_dims();
        case (cmd)
            CMD_CLEAR:
            begin
                stored_points = 0;
                elem_pos      = 0;
            end
            CMD_NONE: ;
            default:
            begin
                is_q = (cmd == CMD_QUERY);
                // A feature of the other kind abandons the partial point.
                if (elem_pos != 0 && is_q != in_query) elem_pos = 0;
                if (elem_pos >= MAX_DIM) elem_pos = 0;
                in_query = is_q;
                last = (elem_pos + 1 >= dims);
                if (!is_q)
                begin
                    if (stored_points < TRAIN_SLOTS)
                    begin
                        point_store[stored_points*MAX_DIM + elem_pos] = feat;
                        if (elem_pos == 0) label_store[stored_points] = lbl;
                    end
                    if (last)
                    begin
                        elem_pos = 0;
                        if (stored_points < TRAIN_SLOTS) stored_points++;
                    end
                    else
                    begin
                        elem_pos++;
                    end
                end
                else
                begin
                    query_vec[elem_pos] = feat;
                    if (!last)
                    begin
                        elem_pos++;
                    end
                    else
                    begin
                        elem_pos = 0;
                        expected_votes.push_back(classify_query(dims, active_k()));
                    end
                end
            end
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        vote_t got;
        vote_t want;
        if (!rst_n)
        begin
            dims_reg      = DIMS_W'(DIMS_RESET);
            k_reg         = K_W'(K_RESET);
            stored_points = 0;
            elem_pos      = 0;
            in_query      = 0;
            err_count     = 0;
            vote_count    = 0;
            expected_votes.delete();
            mismatches    <= 0;
            pending_votes <= 0;
            votes_checked <= 0;
        end
        else
        begin
            if (result_valid)
            begin
                got.label = predicted_label;
                got.used  = neighbours_used;
                if (expected_votes.size() == 0)
                begin
                    err_count++;
                    if (err_count <= 10)
                        $display("%0t: result with none expected: label %0d used %0d",
                                 $realtime, got.label, got.used);
                end
                else
                begin
                    want = expected_votes.pop_front();
                    vote_count++;
                    if (got.label !== want.label || got.used !== want.used)
                    begin
                        err_count++;
                        if (err_count <= 10)
                            $display({"%0t: vote mismatch: label exp %0d got %0d, ",
                                      "used exp %0d got %0d"},
                                     $realtime, want.label, got.label, want.used, got.used);
                    end
                end
            end
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[2]))
                    REG_DIMS: dims_reg = pwdata[DIMS_W-1:0];
                    REG_K:    k_reg    = pwdata[K_W-1:0];
                    default:  ;
                endcase
            end
            if (start && !busy) absorb_item(cmd_e_t'(command), feature_value, train_label);
            mismatches    <= err_count;
            pending_votes <= expected_votes.size();
            votes_checked <= vote_count;
        end
    end

endmodule

>>> tb/knn_binary_classifier_core_test.sv
// Top of the classifier testbench: clock, reset, stimulus, watchdog and verdict.
module knn_binary_classifier_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import knnbc_pkg::*;

    localparam int TRAIN_SLOTS   = 1024;
    localparam int MAX_DIM       = 64;
    localparam int MAX_K         = 15;
    localparam int FEATURE_BITS  = 16;
    localparam int RANDOM_ITEMS  = 800;
    localparam int SETTLE_CYCLES = 8;
    // Well above the longest scan (full store at the widest points) plus a gap.
    localparam int STALL_LIMIT   = 200000;

    logic                    clk             = 1'b0;
    logic                    rst_n           = 1'b0;
    logic                    start           = 1'b0;
    logic                    busy;
    logic [1:0]              command         = CMD_NONE;
    logic [FEATURE_BITS-1:0] feature_value   = '0;
    logic                    train_label     = 1'b0;
    logic                    result_valid;
    logic                    predicted_label;
    logic [K_W-1:0]          neighbours_used;
    logic                    psel            = 1'b0;
    logic                    penable         = 1'b0;
    logic                    pwrite          = 1'b0;
    logic [APB_AW-1:0]       paddr           = '0;
    logic [APB_DW-1:0]       pwdata          = '0;
    logic [APB_DW-1:0]       prdata;
    logic                    pready;

    int mismatch_count;
    int pending_votes;
    int votes_checked;
    int stall_cycles = 0;

    // Stimulus-side view of the block, used only to keep queries off unwritten entries.
    int                tr_count = 0;
    int                elem_idx = 0;
    bit                loading_q = 0;
    int                written_len [TRAIN_SLOTS];
    logic [DIMS_W-1:0] dims_reg = DIMS_W'(DIMS_RESET);

    bit start_on   = 0;
    bit steady     = 0;
    int burst_left = 1;
    int value_mode = 1;
    int items_sent = 0;
    int n_train    = 0;
    int n_query    = 0;
    int n_clear    = 0;
    int n_ignored  = 0;

    always #6 clk = ~clk;

    knn_binary_classifier_core #(
        .TRAIN_SLOTS  (TRAIN_SLOTS),
        .MAX_DIM      (MAX_DIM),
        .MAX_K        (MAX_K),
        .FEATURE_BITS (FEATURE_BITS)
    ) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .command         (command),
        .feature_value   (feature_value),
        .train_label     (train_label),
        .result_valid    (result_valid),
        .predicted_label (predicted_label),
        .neighbours_used (neighbours_used),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    knn_classifier_checker #(
        .TRAIN_SLOTS  (TRAIN_SLOTS),
        .MAX_DIM      (MAX_DIM),
        .MAX_K        (MAX_K),
        .FEATURE_BITS (FEATURE_BITS)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .command         (command),
        .feature_value   (feature_value),
        .train_label     (train_label),
        .result_valid    (result_valid),
        .predicted_label (predicted_label),
        .neighbours_used (neighbours_used),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .mismatches      (mismatch_count),
        .pending_votes   (pending_votes),
        .votes_checked   (votes_checked)
    );

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid || (psel && penable && pwrite && pready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("No transaction for %0d cycles, giving up.", STALL_LIMIT);
            $display("simulation failed");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic int dims_now();
        if (dims_reg == 0) return 1;
        if (dims_reg > MAX_DIM) return MAX_DIM;
        return int'(dims_reg);
    endfunction

    function automatic logic [FEATURE_BITS-1:0] pick_feature();
        case (value_mode)
            0: return FEATURE_BITS'($urandom_range(0, 3));
            1: return FEATURE_BITS'($urandom);
            default:
            begin
                case ($urandom_range(0, 4))
                    0: return '0;
                    1: return '1;
                    2: return {1'b1, {(FEATURE_BITS-1){1'b0}}};
                    3: return {1'b0, {(FEATURE_BITS-1){1'b1}}};
                    default: return FEATURE_BITS'($urandom);
                endcase
            end
        endcase
    endfunction

    // True when this query feature would close a query that reads stored
    // features never written at the current width.
    function automatic bit reads_unwritten();
        int e;
        e = (elem_idx != 0 && !loading_q) ? 0 : elem_idx;
        if (e + 1 < dims_now()) return 0;
        for (int p = 0; p < tr_count; p++)
            if (written_len[p] < dims_now()) return 1;
        return 0;
    endfunction

    function automatic void track(cmd_e_t cmd);
        int e;
        bit is_q;
        case (cmd)
            CMD_CLEAR:
            begin
                tr_count = 0;
                elem_idx = 0;
                n_clear++;
            end
            CMD_NONE: n_ignored++;
            default:
            begin
                is_q = (cmd == CMD_QUERY);
                e = (elem_idx != 0 && is_q != loading_q) ? 0 : elem_idx;
                if (e >= MAX_DIM) e = 0;
                loading_q = is_q;
                if (is_q) n_query++;
                else n_train++;
                if (!is_q && tr_count < TRAIN_SLOTS && written_len[tr_count] < e + 1)
                    written_len[tr_count] = e + 1;
                if (e + 1 >= dims_now())
                begin
                    elem_idx = 0;
                    if (!is_q && tr_count < TRAIN_SLOTS) tr_count++;
                end
                else
                begin
                    elem_idx = e + 1;
                end
            end
        endcase
        if (cmd != CMD_NONE) items_sent++;
    endfunction

    task automatic lower_start();
        if (start_on)
        begin
            start    <= 1'b0;
            start_on = 0;
        end
    endtask

    task automatic transfer(cmd_e_t cmd, logic [FEATURE_BITS-1:0] feat, logic lbl);
        start         <= 1'b1;
        start_on      = 1;
        command       <= cmd;
        feature_value <= feat;
        train_label   <= lbl;
        @(posedge clk);
        while (busy) @(posedge clk);
        track(cmd);
        if (!steady)
        begin
            burst_left--;
            if (burst_left <= 0)
            begin
                lower_start();
                repeat ($urandom_range(1, 8)) @(posedge clk);
                burst_left = $urandom_range(1, 20);
            end
        end
    endtask

    task automatic send_item(cmd_e_t cmd, logic [FEATURE_BITS-1:0] feat, logic lbl);
        if (cmd == CMD_QUERY && reads_unwritten()) transfer(CMD_CLEAR, pick_feature(), 1'b0);
        transfer(cmd, feat, lbl);
    endtask

    task automatic send_point(cmd_e_t cmd, int len);
        logic lbl;
        lbl = $urandom_range(0, 1);
        for (int i = 0; i < len; i++)
            send_item(cmd, pick_feature(), (i == 0) ? lbl : 1'($urandom));
    endtask

    task automatic cfg_write(reg_idx_t idx, logic [APB_DW-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_DIMS) dims_reg = val[DIMS_W-1:0];
        @(posedge clk);
    endtask

    // Wait until every vote is in and the block is idle, then let it drain.
    task automatic settle();
        lower_start();
        @(posedge clk);
        while (pending_votes != 0 || busy) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic directed_phase();
        settle();
        cfg_write(REG_DIMS, '0);
        cfg_write(REG_K, '0);
        send_item(CMD_QUERY, '0, 1'b0);
        send_item(CMD_TRAIN, '0, 1'b0);
        send_item(CMD_TRAIN, '1, 1'b1);
        send_item(CMD_TRAIN, '0, 1'b1);
        send_item(CMD_NONE, 16'h5A5A, 1'b1);
        send_item(CMD_QUERY, '0, 1'b0);
        send_item(CMD_QUERY, '1, 1'b1);

        // Two points at equal distance with opposite labels split the vote.
        settle();
        cfg_write(REG_DIMS, 32'd2);
        cfg_write(REG_K, 32'd2);
        send_item(CMD_CLEAR, '0, 1'b0);
        send_item(CMD_TRAIN, 16'h8000, 1'b0);
        send_item(CMD_TRAIN, 16'h1234, 1'b0);
        send_item(CMD_TRAIN, 16'h8000, 1'b1);
        send_item(CMD_TRAIN, 16'h1236, 1'b1);
        send_item(CMD_QUERY, 16'h8000, 1'b0);
        send_item(CMD_QUERY, 16'h1235, 1'b0);
        send_item(CMD_TRAIN, 16'h0001, 1'b0);
        send_item(CMD_QUERY, 16'h7FFF, 1'b1);
        send_item(CMD_QUERY, 16'h1234, 1'b0);

        // A half-loaded point is finished by its next feature once dims drops.
        send_item(CMD_TRAIN, 16'h4000, 1'b1);
        settle();
        cfg_write(REG_DIMS, 32'd1);
        cfg_write(REG_K, 32'd15);
        send_item(CMD_TRAIN, 16'h4001, 1'b0);
        send_item(CMD_QUERY, 16'h4000, 1'b0);
        send_item(CMD_CLEAR, '0, 1'b0);
        send_item(CMD_QUERY, '1, 1'b1);
    endtask

    task automatic random_phase();
        logic [APB_DW-1:0] dims_val;
        int                nseq;
        int                sel;
        int                dims;
        settle();
        case ($urandom_range(0, 19))
            0:        dims_val = 0;
            1, 2:     dims_val = 1;
            3, 4, 5, 6, 7, 8, 9: dims_val = $urandom_range(2, 4);
            10, 11, 12, 13, 14:  dims_val = $urandom_range(5, 10);
            15, 16:   dims_val = $urandom_range(11, 24);
            17:       dims_val = 64;
            18:       dims_val = 50;
            default:  dims_val = $urandom_range(0, 1) ? 127 : $urandom_range(65, 126);
        endcase
        // Upper bits beyond the register width are junk the block must drop.
        dims_val[APB_DW-1:DIMS_W] = (APB_DW-DIMS_W)'($urandom);
        if ($urandom_range(0, 1))
        begin
            cfg_write(REG_DIMS, dims_val);
            cfg_write(REG_K, $urandom_range(0, 15) | ($urandom << K_W));
        end
        else
        begin
            cfg_write(REG_K, $urandom_range(0, 15) | ($urandom << K_W));
            cfg_write(REG_DIMS, dims_val);
        end
        steady     = ($urandom_range(0, 3) == 0);
        burst_left = $urandom_range(1, 20);
        value_mode = $urandom_range(0, 2);
        dims       = dims_now();
        if (tr_count * dims > 2000) send_item(CMD_CLEAR, '0, 1'b0);
        nseq = (dims <= 10) ? $urandom_range(6, 20) : $urandom_range(2, 4);
        for (int s = 0; s < nseq; s++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 50)
            begin
                send_point(CMD_TRAIN, dims);
            end
            else if (sel < 85)
            begin
                send_point(CMD_QUERY, dims);
            end
            else if (sel < 93)
            begin
                send_point($urandom_range(0, 1) ? CMD_QUERY : CMD_TRAIN,
                           (dims > 1) ? $urandom_range(1, dims - 1) : 1);
            end
            else if (sel < 97)
            begin
                send_item(CMD_NONE, pick_feature(), 1'($urandom));
            end
            else
            begin
                send_item(CMD_CLEAR, pick_feature(), 1'($urandom));
            end
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed_phase();
        while (items_sent < RANDOM_ITEMS)
        begin
            random_phase();
        end
        settle();
        $display("Sent %0d transactions: %0d training and %0d query features, %0d clears,",
                 items_sent + n_ignored, n_train, n_query, n_clear);
        $display("%0d ignored commands; %0d votes checked over random widths and k values.",
                 n_ignored, votes_checked);
        if (pending_votes != 0)
            $display("%0d expected votes never arrived.", pending_votes);
        if (mismatch_count == 0 && pending_votes == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
